### rtl/core/sfd4_pkg.sv
// ============================================================================
// sfd4_pkg
// Shared types, widths and arithmetic helpers of the fourth-order staggered
// grid acoustic cell update unit.
// ============================================================================
package sfd4_pkg;

	localparam int DATA_WIDTH  = 32;
	localparam int FRAC_BITS   = 24;
	localparam int LOSS_WIDTH  = 26;
	localparam int TAPER_WIDTH = 25;

	// difference, stencil sum and scaled-sum widths
	localparam int DIFF_WIDTH = DATA_WIDTH + 1;
	localparam int SUM_WIDTH  = DATA_WIDTH + 7;
	// (|S| + 12) / 8 ranges that still fit a non-clipping divide by three
	localparam int QIN_WIDTH  = DATA_WIDTH + 1;
	localparam int QLO_WIDTH  = QIN_WIDTH / 2;
	localparam int QHI_WIDTH  = QIN_WIDTH - QLO_WIDTH;
	// reciprocal of three: floor(t * DIV3_MUL / 2^DIV3_SHIFT) == floor(t / 3)
	localparam int DIV3_SHIFT = DATA_WIDTH + 2;
	localparam int DIV3_WIDTH = DATA_WIDTH + 1;
	localparam longint unsigned DIV3_MUL_L =
		((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;
	localparam logic [DIV3_WIDTH-1:0] DIV3_MUL = DIV3_WIDTH'(DIV3_MUL_L);
	localparam int DIV3_PROD_WIDTH = QIN_WIDTH + DIV3_WIDTH;

	// working width of round and saturate helpers
	localparam int WIDE = 2 * DATA_WIDTH + 8;

	// cycles from accepted item to result strobe
	localparam int LATENCY = 14;

	localparam logic signed [WIDE-1:0] SAT_HI = (WIDE'(1) <<< (DATA_WIDTH - 1)) - WIDE'(1);
	localparam logic signed [WIDE-1:0] SAT_LO = -(WIDE'(1) <<< (DATA_WIDTH - 1));

	typedef struct packed {
		logic                          func;
		logic signed [DATA_WIDTH-1:0]  old_value;
		logic signed [DATA_WIDTH-1:0]  coef;
		logic signed [DATA_WIDTH-1:0]  first_near_hi;
		logic signed [DATA_WIDTH-1:0]  first_near_lo;
		logic signed [DATA_WIDTH-1:0]  first_far_hi;
		logic signed [DATA_WIDTH-1:0]  first_far_lo;
		logic signed [DATA_WIDTH-1:0]  second_near_hi;
		logic signed [DATA_WIDTH-1:0]  second_near_lo;
		logic signed [DATA_WIDTH-1:0]  second_far_hi;
		logic signed [DATA_WIDTH-1:0]  second_far_lo;
		logic        [TAPER_WIDTH-1:0] taper;
	} sfd4_item_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] new_value;
		logic                         saturated;
	} sfd4_result_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] val;
		logic                         clip;
	} sfd4_sat_t;

	localparam logic FUNC_VELOCITY = 1'b0;
	localparam logic FUNC_PRESSURE = 1'b1;

	// clip to the data range, report clipping
	function automatic sfd4_sat_t sat_dw(input logic signed [WIDE-1:0] x);
		sfd4_sat_t r;
		if (x > SAT_HI) begin
			r.val  = DATA_WIDTH'(SAT_HI);
			r.clip = 1'b1;
		end else if (x < SAT_LO) begin
			r.val  = DATA_WIDTH'(SAT_LO);
			r.clip = 1'b1;
		end else begin
			r.val  = DATA_WIDTH'(x);
			r.clip = 1'b0;
		end
		return r;
	endfunction

	// x / 2^sh, rounded to nearest, ties away from zero
	function automatic logic signed [WIDE-1:0] rnd_shr(input logic signed [WIDE-1:0] x,
		input int sh);
		logic signed [WIDE-1:0] bias;
		logic signed [WIDE-1:0] tot;
		bias = (WIDE'(1) <<< (sh - 1)) - WIDE'(x[WIDE-1]);
		tot  = x + bias;
		return tot >>> sh;
	endfunction

endpackage

### rtl/core/staggered_fd4_acoustic_cell_update_unit.sv
// ============================================================================
// staggered_fd4_acoustic_cell_update_unit
// Fourth-order staggered-grid acoustic update of one grid point, velocity or
// pressure mode, with loss term, taper and saturation; Q8.24 data.
// ============================================================================
// Throughput: one item per cycle; busy stays low, the 14-stage pipeline
// never stalls since the receiver takes each result in its strobe cycle.
// Reset: arst_n clears the stage valid bits and loss_factor (to zero);
// items in flight are dropped. Pipeline payload is not reset.
module staggered_fd4_acoustic_cell_update_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  sfd4_pkg::sfd4_item_t                    item,
	output logic                                    done,
	output sfd4_pkg::sfd4_result_t                  result,
	input  logic                                    loss_factor_we,
	input  logic signed [sfd4_pkg::LOSS_WIDTH-1:0]  loss_factor_wdata
);
	import sfd4_pkg::*;

	localparam int LPROD_WIDTH = DIFF_WIDTH + LOSS_WIDTH;
	localparam int TPROD_WIDTH = DATA_WIDTH + TAPER_WIDTH + 1;

	logic signed [LOSS_WIDTH-1:0] loss_factor_q;

	// stage valid bits
	logic [LATENCY-1:0] vld_q;
	logic               accept;

	// ---- stage registers ----
	// s1: raw differences of each neighbor pair
	logic signed [DIFF_WIDTH-1:0]  d1n_s1, d1f_s1, d2n_s1, d2f_s1;
	logic                          func_s1;
	logic signed [DATA_WIDTH-1:0]  old_s1, coef_s1;
	logic        [TAPER_WIDTH-1:0] taper_s1;
	// s2: 24 * derivative, exact
	logic signed [SUM_WIDTH-1:0]   sum_s2;
	logic                          func_s2;
	logic signed [DATA_WIDTH-1:0]  old_s2, coef_s2;
	logic        [TAPER_WIDTH-1:0] taper_s2;
	// s3: sign and (|S| + 12) / 8
	logic                          neg_s3, big_s3;
	logic        [QIN_WIDTH-1:0]   t_s3;
	logic                          func_s3;
	logic signed [DATA_WIDTH-1:0]  old_s3, coef_s3;
	logic        [TAPER_WIDTH-1:0] taper_s3;
	// s4: reciprocal partial products
	logic                          neg_s4, big_s4;
	logic [QLO_WIDTH+DIV3_WIDTH-1:0] pplo_s4;
	logic [QHI_WIDTH+DIV3_WIDTH-1:0] pphi_s4;
	logic                          func_s4;
	logic signed [DATA_WIDTH-1:0]  old_s4, coef_s4;
	logic        [TAPER_WIDTH-1:0] taper_s4;
	// s5: derivative D
	logic signed [DATA_WIDTH-1:0]  d_s5;
	logic                          sat_s5;
	logic                          func_s5;
	logic signed [DATA_WIDTH-1:0]  old_s5, coef_s5;
	logic        [TAPER_WIDTH-1:0] taper_s5;
	// s6: coef * D
	logic signed [2*DATA_WIDTH-1:0] prod_s6;
	logic                          sat_s6, func_s6;
	logic signed [DATA_WIDTH-1:0]  old_s6;
	logic        [TAPER_WIDTH-1:0] taper_s6;
	// s7: P
	logic signed [DATA_WIDTH-1:0]  p_s7;
	logic                          sat_s7, func_s7;
	logic signed [DATA_WIDTH-1:0]  old_s7;
	logic        [TAPER_WIDTH-1:0] taper_s7;
	// s8: v1
	logic signed [DATA_WIDTH-1:0]  v1_s8;
	logic                          sat_s8, func_s8;
	logic signed [DATA_WIDTH-1:0]  old_s8;
	logic        [TAPER_WIDTH-1:0] taper_s8;
	// s9: v1 + old, exact
	logic signed [DIFF_WIDTH-1:0]  vsum_s9;
	logic signed [DATA_WIDTH-1:0]  v1_s9;
	logic                          sat_s9, func_s9;
	logic        [TAPER_WIDTH-1:0] taper_s9;
	// s10: (v1 + old) * qr
	logic signed [LPROD_WIDTH-1:0] lprod_s10;
	logic signed [DATA_WIDTH-1:0]  v1_s10;
	logic                          sat_s10, func_s10;
	logic        [TAPER_WIDTH-1:0] taper_s10;
	// s11: loss term L
	logic signed [DATA_WIDTH-1:0]  l_s11, v1_s11;
	logic                          sat_s11, func_s11;
	logic        [TAPER_WIDTH-1:0] taper_s11;
	// s12: v2
	logic signed [DATA_WIDTH-1:0]  v2_s12;
	logic                          sat_s12, func_s12;
	logic        [TAPER_WIDTH-1:0] taper_s12;
	// s13: v2 * taper
	logic signed [TPROD_WIDTH-1:0] tprod_s13;
	logic signed [DATA_WIDTH-1:0]  v2_s13;
	logic                          sat_s13, func_s13;
	// s14: result
	sfd4_result_t                  res_s14;

	// ---- combinational helpers ----
	logic signed [SUM_WIDTH-1:0]  e1n, e1f, e2n, e2f, pair1, pair2;
	logic        [SUM_WIDTH-1:0]  mag2, tfull2;
	logic [DIV3_PROD_WIDTH-1:0]   qfull4;
	logic [DATA_WIDTH-1:0]        q4;
	logic                         clip4;
	sfd4_sat_t                    p6, v7, l10, v11, r13;

	assign accept = start && !busy;
	assign busy   = 1'b0;
	assign done   = vld_q[LATENCY-1];
	assign result = res_s14;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_factor_q <= '0;
		end else if (loss_factor_we) begin
			loss_factor_q <= loss_factor_wdata;
		end
	end

	// valid bits walk with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], accept};
		end
	end

	// stencil: 27*(near) - (far) per pair; second pair in pressure mode only
	always_comb begin
		e1n   = SUM_WIDTH'(d1n_s1);
		e1f   = SUM_WIDTH'(d1f_s1);
		e2n   = SUM_WIDTH'(d2n_s1);
		e2f   = SUM_WIDTH'(d2f_s1);
		pair1 = (e1n <<< 4) + (e1n <<< 3) + (e1n <<< 1) + e1n - e1f;
		pair2 = (e2n <<< 4) + (e2n <<< 3) + (e2n <<< 1) + e2n - e2f;
	end

	// |S| + 12 then / 8; the /3 follows through a reciprocal
	always_comb begin
		mag2   = sum_s2[SUM_WIDTH-1] ? SUM_WIDTH'(-sum_s2) : SUM_WIDTH'(sum_s2);
		tfull2 = (mag2 + SUM_WIDTH'(12)) >> 3;
	end

	// D = t / 3, clipped by sign
	always_comb begin
		qfull4 = (DIV3_PROD_WIDTH'(pphi_s4) << QLO_WIDTH) + DIV3_PROD_WIDTH'(pplo_s4);
		q4     = DATA_WIDTH'(qfull4 >> DIV3_SHIFT);
		if (neg_s4) begin
			clip4 = big_s4 || (q4 > (DATA_WIDTH'(1) << (DATA_WIDTH - 1)));
		end else begin
			clip4 = big_s4 || q4[DATA_WIDTH-1];
		end
	end

	always_comb begin
		p6  = sat_dw(rnd_shr(WIDE'(prod_s6), FRAC_BITS));
		v7  = sat_dw(WIDE'(old_s7) - WIDE'(p_s7));
		l10 = sat_dw(rnd_shr(WIDE'(lprod_s10), FRAC_BITS + 1));
		v11 = sat_dw(WIDE'(v1_s11) + WIDE'(l_s11));
		r13 = sat_dw(rnd_shr(WIDE'(tprod_s13), FRAC_BITS));
	end

	// pipeline payload, no reset
	always_ff @(posedge clk) begin
		// s1
		d1n_s1   <= DIFF_WIDTH'(item.first_near_hi) - DIFF_WIDTH'(item.first_near_lo);
		d1f_s1   <= DIFF_WIDTH'(item.first_far_hi) - DIFF_WIDTH'(item.first_far_lo);
		d2n_s1   <= DIFF_WIDTH'(item.second_near_hi) - DIFF_WIDTH'(item.second_near_lo);
		d2f_s1   <= DIFF_WIDTH'(item.second_far_hi) - DIFF_WIDTH'(item.second_far_lo);
		func_s1  <= item.func;
		old_s1   <= item.old_value;
		coef_s1  <= item.coef;
		taper_s1 <= item.taper;
		// s2
		sum_s2   <= (func_s1 == FUNC_PRESSURE) ? pair1 + pair2 : pair1;
		func_s2  <= func_s1;
		old_s2   <= old_s1;
		coef_s2  <= coef_s1;
		taper_s2 <= taper_s1;
		// s3
		neg_s3   <= sum_s2[SUM_WIDTH-1];
		big_s3   <= |tfull2[SUM_WIDTH-1:QIN_WIDTH];
		t_s3     <= tfull2[QIN_WIDTH-1:0];
		func_s3  <= func_s2;
		old_s3   <= old_s2;
		coef_s3  <= coef_s2;
		taper_s3 <= taper_s2;
		// s4
		neg_s4   <= neg_s3;
		big_s4   <= big_s3;
		pplo_s4  <= (QLO_WIDTH+DIV3_WIDTH)'(t_s3[QLO_WIDTH-1:0]) *
			(QLO_WIDTH+DIV3_WIDTH)'(DIV3_MUL);
		pphi_s4  <= (QHI_WIDTH+DIV3_WIDTH)'(t_s3[QIN_WIDTH-1:QLO_WIDTH]) *
			(QHI_WIDTH+DIV3_WIDTH)'(DIV3_MUL);
		func_s4  <= func_s3;
		old_s4   <= old_s3;
		coef_s4  <= coef_s3;
		taper_s4 <= taper_s3;
		// s5
		if (clip4) begin
			d_s5 <= neg_s4 ? DATA_WIDTH'(SAT_LO) : DATA_WIDTH'(SAT_HI);
		end else begin
			d_s5 <= neg_s4 ? -$signed(q4) : $signed(q4);
		end
		sat_s5   <= clip4;
		func_s5  <= func_s4;
		old_s5   <= old_s4;
		coef_s5  <= coef_s4;
		taper_s5 <= taper_s4;
		// s6
		prod_s6  <= (2*DATA_WIDTH)'(coef_s5) * (2*DATA_WIDTH)'(d_s5);
		sat_s6   <= sat_s5;
		func_s6  <= func_s5;
		old_s6   <= old_s5;
		taper_s6 <= taper_s5;
		// s7
		p_s7     <= p6.val;
		sat_s7   <= sat_s6 | p6.clip;
		func_s7  <= func_s6;
		old_s7   <= old_s6;
		taper_s7 <= taper_s6;
		// s8
		v1_s8    <= v7.val;
		sat_s8   <= sat_s7 | v7.clip;
		func_s8  <= func_s7;
		old_s8   <= old_s7;
		taper_s8 <= taper_s7;
		// s9
		vsum_s9  <= DIFF_WIDTH'(v1_s8) + DIFF_WIDTH'(old_s8);
		v1_s9    <= v1_s8;
		sat_s9   <= sat_s8;
		func_s9  <= func_s8;
		taper_s9 <= taper_s8;
		// s10
		lprod_s10 <= LPROD_WIDTH'(vsum_s9) * LPROD_WIDTH'(loss_factor_q);
		v1_s10    <= v1_s9;
		sat_s10   <= sat_s9;
		func_s10  <= func_s9;
		taper_s10 <= taper_s9;
		// s11
		l_s11     <= l10.val;
		v1_s11    <= v1_s10;
		sat_s11   <= sat_s10 | l10.clip;
		func_s11  <= func_s10;
		taper_s11 <= taper_s10;
		// s12
		v2_s12    <= v11.val;
		sat_s12   <= sat_s11 | v11.clip;
		func_s12  <= func_s11;
		taper_s12 <= taper_s11;
		// s13: taper is unsigned, zero-extended into the signed product
		tprod_s13 <= TPROD_WIDTH'(v2_s12) *
			$signed(TPROD_WIDTH'({1'b0, taper_s12}));
		v2_s13    <= v2_s12;
		sat_s13   <= sat_s12;
		func_s13  <= func_s12;
		// s14: pressure mode skips the taper
		if (func_s13 == FUNC_PRESSURE) begin
			res_s14.new_value <= v2_s13;
			res_s14.saturated <= sat_s13;
		end else begin
			res_s14.new_value <= r13.val;
			res_s14.saturated <= sat_s13 | r13.clip;
		end
	end

endmodule

### rtl/core/sfd4_checker.sv
// ============================================================================
// sfd4_checker
// Port-level timing checks of the acoustic cell update unit, bound to it.
// ============================================================================
module sfd4_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	import sfd4_pkg::*;

	// no back-pressure: an item is taken every cycle
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// each accepted item gives a strobe after the fixed latency
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result strobe missing");

	// no strobe without an item accepted one latency earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("unexpected result strobe");

endmodule

bind staggered_fd4_acoustic_cell_update_unit sfd4_checker u_sfd4_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

### sim/tb_staggered_fd4_acoustic_cell_update_unit.sv
// ----------------------------------------------------------------------------
// tb_staggered_fd4_acoustic_cell_update_unit
// Self-checking bench for the fourth-order staggered-grid cell update. A
// directed table covers field extremes, saturation, rounding ties and the
// unused-field cases. Random grid points follow under several loss factors
// and idle patterns. Results are compared with an independent fixed-point
// predictor, or with hand values typed in for the pinned directed rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_staggered_fd4_acoustic_cell_update_unit;

	import sfd4_pkg::*;

	// wide enough for every intermediate product without wrap
	typedef logic signed [127:0] wide_t;

	typedef struct {
		sfd4_item_t   pt;
		bit           pinned;   // expected result typed in below
		sfd4_result_t res;
	} dir_row_t;

	localparam logic signed [DATA_WIDTH-1:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_WIDTH-1:0] Q_MIN = 32'sh80000000;
	localparam logic signed [DATA_WIDTH-1:0] Q_ONE = 32'sh01000000;
	localparam logic [TAPER_WIDTH-1:0] TAPER_ONE = 25'h1000000;
	localparam logic [TAPER_WIDTH-1:0] TAPER_MAX = 25'h1ffffff;
	localparam logic signed [LOSS_WIDTH-1:0] LOSS_ONE = 26'sh1000000;

	localparam int RANDOM_PER_PHASE = 200;
	localparam int PHASES           = 5;
	localparam int PAUSE_PHASE      = 3;
	localparam int CYCLE_LIMIT      = 200000;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         start;
	logic         busy;
	sfd4_item_t   item;
	logic         done;
	sfd4_result_t result;
	logic         loss_factor_we;
	logic signed [LOSS_WIDTH-1:0] loss_factor_wdata;

	// bench copy of the loss register, follows every write
	logic signed [LOSS_WIDTH-1:0] loss_now;

	// expected results, oldest first
	sfd4_result_t pending_results[$];
	sfd4_result_t want;

	// directed rows may carry a hand-computed result instead of a prediction
	bit           pinned_valid;
	sfd4_result_t pinned_result;

	int mismatch_count;
	int cycle_count;

	dir_row_t directed_rows[$];

	staggered_fd4_acoustic_cell_update_unit dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.item              (item),
		.done              (done),
		.result            (result),
		.loss_factor_we    (loss_factor_we),
		.loss_factor_wdata (loss_factor_wdata)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// clip to the signed data range and flag it
	function automatic sfd4_sat_t clip_data(input wide_t x);
		sfd4_sat_t r;
		wide_t     hi;
		wide_t     lo;
		hi = (wide_t'(1) <<< (DATA_WIDTH - 1)) - 1;
		lo = -(wide_t'(1) <<< (DATA_WIDTH - 1));
		r.clip = (x > hi) || (x < lo);
		if (x > hi) begin
			r.val = DATA_WIDTH'(hi);
		end else if (x < lo) begin
			r.val = DATA_WIDTH'(lo);
		end else begin
			r.val = DATA_WIDTH'(x);
		end
		return r;
	endfunction

	// x / 2^sh, nearest, ties away from zero (done on the magnitude)
	function automatic wide_t round_shift(input wide_t x, input int sh);
		wide_t mag;
		wide_t q;
		mag = (x < 0) ? -x : x;
		q = (mag + (wide_t'(1) <<< (sh - 1))) >>> sh;
		return (x < 0) ? -q : q;
	endfunction

	// one grid point: stencil derivative, coefficient, loss term, taper
	function automatic sfd4_result_t cell_update_expected(input sfd4_item_t pt,
		input logic signed [LOSS_WIDTH-1:0] qr);
		wide_t        s, mag, d, p, v1, l, v2, o, k, lf, tp;
		sfd4_sat_t    c;
		sfd4_result_t r;
		bit           clipped;
		clipped = 1'b0;
		o  = pt.old_value;
		k  = pt.coef;
		lf = qr;
		tp = pt.taper;

		// 24 * derivative: 27*(near diff) - (far diff), exact
		s = 27 * (wide_t'(pt.first_near_hi) - wide_t'(pt.first_near_lo))
			- (wide_t'(pt.first_far_hi) - wide_t'(pt.first_far_lo));
		if (pt.func == FUNC_PRESSURE) begin
			s = s + 27 * (wide_t'(pt.second_near_hi) - wide_t'(pt.second_near_lo))
				- (wide_t'(pt.second_far_hi) - wide_t'(pt.second_far_lo));
		end

		mag = (s < 0) ? -s : s;
		mag = (mag + 12) / 24;
		c = clip_data((s < 0) ? -mag : mag);
		d = c.val;
		clipped |= c.clip;

		c = clip_data(round_shift(k * d, FRAC_BITS));
		p = c.val;
		clipped |= c.clip;

		c = clip_data(o - p);
		v1 = c.val;
		clipped |= c.clip;

		// loss: half of (new + old) times qr, sum kept exact
		c = clip_data(round_shift((v1 + o) * lf, FRAC_BITS + 1));
		l = c.val;
		clipped |= c.clip;

		c = clip_data(v1 + l);
		v2 = c.val;
		clipped |= c.clip;

		if (pt.func == FUNC_VELOCITY) begin
			c = clip_data(round_shift(v2 * tp, FRAC_BITS));
			clipped |= c.clip;
		end
		r.new_value = c.val;
		r.saturated = clipped;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic sfd4_item_t grid_point(input logic f,
		input logic signed [DATA_WIDTH-1:0] old_v, k,
		input logic signed [DATA_WIDTH-1:0] a1, b1, c1, d1, a2, b2, c2, d2,
		input logic [TAPER_WIDTH-1:0] tp);
		sfd4_item_t pt;
		pt.func           = f;
		pt.old_value      = old_v;
		pt.coef           = k;
		pt.first_near_hi  = a1;
		pt.first_near_lo  = b1;
		pt.first_far_hi   = c1;
		pt.first_far_lo   = d1;
		pt.second_near_hi = a2;
		pt.second_near_lo = b2;
		pt.second_far_hi  = c2;
		pt.second_far_lo  = d2;
		pt.taper          = tp;
		return pt;
	endfunction

	// random word shrunk by a random arithmetic shift: spans all magnitudes
	function automatic logic signed [DATA_WIDTH-1:0] rand_scaled(input int min_shift);
		return $signed($urandom) >>> $urandom_range(31, min_shift);
	endfunction

	function automatic sfd4_item_t random_point();
		sfd4_item_t pt;
		logic signed [DATA_WIDTH-1:0] base;
		pt.func = ($urandom_range(1) == 1) ? FUNC_PRESSURE : FUNC_VELOCITY;
		if ($urandom_range(9) < 7) begin
			// smooth field: neighbours close to a common level, so most stages
			// stay in range and the rounding paths get exercised
			base              = rand_scaled(0);
			pt.old_value      = rand_scaled(4);
			pt.coef           = rand_scaled(4);
			pt.first_near_hi  = base + rand_scaled(8);
			pt.first_near_lo  = base + rand_scaled(8);
			pt.first_far_hi   = base + rand_scaled(8);
			pt.first_far_lo   = base + rand_scaled(8);
			pt.second_near_hi = base + rand_scaled(8);
			pt.second_near_lo = base + rand_scaled(8);
			pt.second_far_hi  = base + rand_scaled(8);
			pt.second_far_lo  = base + rand_scaled(8);
		end else begin
			// raw noise, mostly saturating
			pt.old_value      = $urandom;
			pt.coef           = $urandom;
			pt.first_near_hi  = $urandom;
			pt.first_near_lo  = $urandom;
			pt.first_far_hi   = $urandom;
			pt.first_far_lo   = $urandom;
			pt.second_near_hi = $urandom;
			pt.second_near_lo = $urandom;
			pt.second_far_hi  = $urandom;
			pt.second_far_lo  = $urandom;
		end
		case ($urandom_range(3))
			0, 1: pt.taper = TAPER_ONE;
			2: pt.taper = TAPER_WIDTH'($urandom_range(TAPER_ONE));
			default: pt.taper = TAPER_WIDTH'($urandom);
		endcase
		return pt;
	endfunction

	// ------------------------------------------------------------------------
	// Driving (falling edge)
	// ------------------------------------------------------------------------

	// offer one item after a random number of idle cycles, hold until taken
	task automatic send_point(input sfd4_item_t pt, input bit pinned,
		input sfd4_result_t res, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start         = 1'b1;
		item          = pt;
		pinned_valid  = pinned;
		pinned_result = res;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// idle the input until every expected result has come back
	task automatic drain_results();
		start = 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_loss(input logic signed [LOSS_WIDTH-1:0] qr);
		loss_factor_we    = 1'b1;
		loss_factor_wdata = qr;
		@(negedge clk);
		loss_factor_we    = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Scoreboard (rising edge): results leave the queue before new
	// predictions enter, all in one process so nothing races
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_now <= '0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with none expected: value %h, flag %b",
						$time, result.new_value, result.saturated);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (result.new_value !== want.new_value) begin
						$display("%0t: new_value expected %h, actual %h",
							$time, want.new_value, result.new_value);
						mismatch_count++;
					end
					if (result.saturated !== want.saturated) begin
						$display("%0t: saturated expected %b, actual %b",
							$time, want.saturated, result.saturated);
						mismatch_count++;
					end
				end
			end
			if (start && !busy) begin
				if (pinned_valid) begin
					pending_results.push_back(pinned_result);
				end else begin
					pending_results.push_back(cell_update_expected(item, loss_now));
				end
			end
			if (loss_factor_we) begin
				loss_now <= loss_factor_wdata;
			end
		end
	end

	// run-away guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic signed [LOSS_WIDTH-1:0] qr;
		int idle_pct;

		arst_n            = 1'b0;
		start             = 1'b0;
		item              = '0;
		loss_factor_we    = 1'b0;
		loss_factor_wdata = '0;
		pinned_valid      = 1'b0;
		pinned_result     = '0;
		mismatch_count    = 0;
		cycle_count       = 0;

		// Directed table, loss factor still at its reset value of zero.
		// Hand results: zero point; old value passed through at both
		// extremes; derivative and product clip; taper above one clips;
		// taper ignored in pressure mode; second pair ignored in velocity
		// mode; second pair clipping both ways in pressure mode.
		directed_rows.push_back('{grid_point(FUNC_VELOCITY, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 25'h0), 1'b1, '{32'sh0, 1'b0}});
		directed_rows.push_back('{grid_point(FUNC_VELOCITY, Q_MAX, 0, 0, 0, 0, 0,
			0, 0, 0, 0, TAPER_ONE), 1'b1, '{Q_MAX, 1'b0}});
		directed_rows.push_back('{grid_point(FUNC_VELOCITY, Q_MIN, 0, 0, 0, 0, 0,
			0, 0, 0, 0, TAPER_ONE), 1'b1, '{Q_MIN, 1'b0}});
		directed_rows.push_back('{grid_point(FUNC_VELOCITY, 0, Q_MAX, Q_MAX, Q_MIN,
			0, 0, 0, 0, 0, 0, TAPER_ONE), 1'b1, '{32'sh80000001, 1'b1}});
		directed_rows.push_back('{grid_point(FUNC_VELOCITY, Q_MAX, 0, 0, 0, 0, 0,
			0, 0, 0, 0, TAPER_MAX), 1'b1, '{Q_MAX, 1'b1}});
		directed_rows.push_back('{grid_point(FUNC_PRESSURE, 5, 0, 0, 0, 0, 0,
			0, 0, 0, 0, TAPER_MAX), 1'b1, '{32'sh5, 1'b0}});
		directed_rows.push_back('{grid_point(FUNC_VELOCITY, 5, Q_ONE, 0, 0, 0, 0,
			Q_MAX, Q_MIN, Q_MIN, Q_MAX, TAPER_ONE), 1'b1, '{32'sh5, 1'b0}});
		directed_rows.push_back('{grid_point(FUNC_PRESSURE, 0, Q_ONE, 0, 0, 0, 0,
			Q_MAX, Q_MIN, 0, 0, TAPER_ONE), 1'b1, '{32'sh80000001, 1'b1}});
		directed_rows.push_back('{grid_point(FUNC_PRESSURE, 0, Q_ONE, 0, 0, 0, 0,
			Q_MIN, Q_MAX, 0, 0, TAPER_ONE), 1'b1, '{Q_MAX, 1'b1}});
		// predicted rows: derivative rounding ties and just below, product
		// tie, all-extreme fields, alternating bit patterns, coef at minimum
		directed_rows.push_back('{grid_point(FUNC_VELOCITY, 32'sh100, Q_ONE, 0, 0,
			0, 12, 0, 0, 0, 0, TAPER_ONE), 1'b0, '0});
		directed_rows.push_back('{grid_point(FUNC_VELOCITY, 32'sh100, Q_ONE, 0, 0,
			12, 0, 0, 0, 0, 0, TAPER_ONE), 1'b0, '0});
		directed_rows.push_back('{grid_point(FUNC_VELOCITY, 32'sh100, Q_ONE, 0, 0,
			0, 11, 0, 0, 0, 0, TAPER_ONE), 1'b0, '0});
		directed_rows.push_back('{grid_point(FUNC_PRESSURE, 32'sh100, 32'sh00800000,
			0, 0, 0, 12, 0, 0, 0, 0, TAPER_ONE), 1'b0, '0});
		directed_rows.push_back('{grid_point(FUNC_VELOCITY, Q_MAX, Q_MAX, Q_MAX,
			Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, TAPER_MAX), 1'b0, '0});
		directed_rows.push_back('{grid_point(FUNC_PRESSURE, Q_MIN, Q_MIN, Q_MIN,
			Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 25'h0), 1'b0, '0});
		directed_rows.push_back('{grid_point(FUNC_VELOCITY, 32'sh55555555,
			32'sh55555555, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa,
			32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 25'h0aaaaaa),
			1'b0, '0});
		directed_rows.push_back('{grid_point(FUNC_PRESSURE, 32'shaaaaaaaa,
			32'shaaaaaaaa, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555,
			32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 25'h1555555),
			1'b0, '0});
		directed_rows.push_back('{grid_point(FUNC_VELOCITY, 32'sh01000000, Q_MIN,
			27, 0, 0, 1, 0, 0, 0, 0, TAPER_ONE), 1'b0, '0});

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			send_point(directed_rows[i].pt, directed_rows[i].pinned,
				directed_rows[i].res, 0);
		end
		pinned_valid = 1'b0;

		// Random phases: each one drains, sets a new loss factor, then
		// streams points with its own idle density.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			case (ph)
				0: begin
					qr = LOSS_ONE;
					idle_pct = 0;
				end
				1: begin
					qr = -LOSS_ONE;
					idle_pct = 77;
				end
				2: begin
					qr = LOSS_WIDTH'($urandom_range(1 << 25) - (1 << 24));
					idle_pct = 29;
				end
				3: begin
					qr = '0;
					idle_pct = 0;
				end
				default: begin
					qr = LOSS_WIDTH'($urandom_range(1 << 25) - (1 << 24));
					idle_pct = 77;
				end
			endcase
			write_loss(qr);
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// once mid-phase, let the pipeline run dry before resuming
				if (ph == PAUSE_PHASE && n == RANDOM_PER_PHASE / 2) begin
					drain_results();
				end
				send_point(random_point(), 1'b0, '0, idle_pct);
			end
		end

		drain_results();
		// catch any stray strobe after the last expected result
		repeat (LATENCY + 4) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### staggered_fd4_acoustic_cell_update_unit.f
rtl/core/sfd4_pkg.sv
rtl/core/staggered_fd4_acoustic_cell_update_unit.sv
rtl/core/sfd4_checker.sv
sim/tb_staggered_fd4_acoustic_cell_update_unit.sv
